[src/aho_corasick_multi_pattern_matcher_macros.svh]
// assertion helpers
`ifndef AHO_CORASICK_MULTI_PATTERN_MATCHER_MACROS_SVH
`define AHO_CORASICK_MULTI_PATTERN_MATCHER_MACROS_SVH
`define ACM_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ACM_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

[src/acm_pkg.sv]
`timescale 1ns / 1ps
package acm_pkg;
	typedef enum logic [2:0] {
		FN_CLEAR = 3'd0, FN_LETTER = 3'd1, FN_END = 3'd2, FN_BUILD = 3'd3, FN_TEXT = 3'd4
	} func_t;
	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_BUILT = 2'd2
	} status_t;
	typedef struct packed {
		logic [2:0]  func;
		logic [4:0]  symbol;
		logic        pattern_tagged;
		logic [3:0]  pattern_number;
	} in_item_t;
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  matches_here;
		logic [31:0] total_matches;
		logic [15:0] pattern_mask;
	} out_item_t;
	localparam int MASK_W = 16;
endpackage

[src/acm_stream_if.sv]
`timescale 1ns / 1ps
interface acm_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/acm_ram.sv]
`timescale 1ns / 1ps
module acm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[src/aho_corasick_multi_pattern_matcher.sv]
`timescale 1ns / 1ps
// Aho-Corasick matcher. One request on in_ch gives one result on out_ch.
// func selects: clear, pattern letter, end pattern, build links, text letter.
// Requests are handled one at a time by a sequencer over node memories
// (goto, child/end word, failure link, suffix count, suffix mask, BFS queue),
// each a RAM with a registered read. in_ch is ready only when idle.
// A text letter follows failure links until a node has the letter or the root
// is reached; build walks the trie breadth first and, for each child, walks
// failure links from the parent's failure node.
// A new node has its child word and mask cleared as it is made, so no sweep
// is needed: reset and clear only rewrite the root.
// Reset: the trie holds only the root, nothing is built, total is zero; the
// block is ready once the boot state has rewritten the root.
// The result sits in an output register. A stalled receiver holds it there;
// the next request may still be accepted and worked on, and its result waits
// in the sequencer until the register is free.
`include "aho_corasick_multi_pattern_matcher_macros.svh"
module aho_corasick_multi_pattern_matcher #(
	parameter int NODES    = 256,
	parameter int ALPHABET = 26,
	parameter int PATTERNS = 16
) (
	input logic clk,
	input logic arst_n,
	acm_stream_if.sink   in_ch,
	acm_stream_if.source out_ch
);
	import acm_pkg::*;
	localparam int NW = $clog2(NODES);
	localparam int SW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int GW = NW + SW;
	localparam int CW = NW + 1;
	localparam int VW = ALPHABET + 1;
	// top bit of the child word marks the end of a pattern
	localparam logic [VW-1:0] END_BIT = {1'b1, {ALPHABET{1'b0}}};

	typedef enum logic [4:0] {
		S_BOOT, S_IDLE, S_CLR, S_L_RD, S_L_DO, S_L_NEW, S_E_RD, S_E_DO,
		S_B_INIT, S_B_POP, S_B_POPW, S_B_URD, S_B_UWT, S_B_SYM, S_B_GWT,
		S_B_PRD, S_B_PWT, S_B_CRD, S_B_CWT, S_B_MWT,
		S_T_RD, S_T_WT, S_T_RES, S_T_DONE, S_OUT
	} state_t;
	state_t state_q;

	logic [CW-1:0]       used_q;
	logic [NW-1:0]       ins_q, mcur_q, u_q, fu_q, p_q, c_q, f_q;
	logic [CW-1:0]       head_q, tail_q;
	logic [SW-1:0]       s_q;
	logic [ALPHABET-1:0] ucv_q;
	logic [31:0]         total_q;
	logic                built_q, ovf_q;
	in_item_t            req_q;
	out_item_t           wk_q;
	out_item_t           res_q;
	logic                res_v_q;
	logic [7:0]          cnt_f_q;
	logic [MASK_W-1:0]   msk_f_q;
	logic                endc_q;

	// memories
	logic g_we; logic [GW-1:0] g_wa, g_ra; logic [NW-1:0] g_wd, g_rd;
	logic v_we; logic [NW-1:0] v_wa, v_ra; logic [VW-1:0] v_wd, v_rd;
	logic f_we; logic [NW-1:0] f_wa, f_ra, f_wd, f_rd;
	logic n_we; logic [NW-1:0] n_wa, n_ra; logic [7:0] n_wd, n_rd;
	logic m_we; logic [NW-1:0] m_wa, m_ra; logic [MASK_W-1:0] m_wd, m_rd;
	logic q_we; logic [NW-1:0] q_wa, q_ra, q_wd, q_rd;

	acm_ram #(.WIDTH(NW), .DEPTH(NODES*(1<<SW))) u_goto (.clk, .we(g_we), .waddr(g_wa),
		.wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
	acm_ram #(.WIDTH(VW), .DEPTH(NODES)) u_child (.clk, .we(v_we), .waddr(v_wa),
		.wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
	acm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (.clk, .we(f_we), .waddr(f_wa),
		.wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
	acm_ram #(.WIDTH(8), .DEPTH(NODES)) u_cnt (.clk, .we(n_we), .waddr(n_wa),
		.wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
	acm_ram #(.WIDTH(MASK_W), .DEPTH(NODES)) u_mask (.clk, .we(m_we), .waddr(m_wa),
		.wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
	acm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (.clk, .we(q_we), .waddr(q_wa),
		.wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

	logic sym_ok;
	assign sym_ok = ({27'd0, req_q.symbol} < ALPHABET);
	logic [SW-1:0] rsym;
	assign rsym = SW'(req_q.symbol);

	logic out_load;
	assign out_load = (state_q == S_OUT) && (!res_v_q || out_ch.ready);

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = res_v_q;
	assign out_ch.data  = res_q;

	logic [MASK_W-1:0] tag_bit;
	always_comb begin
		tag_bit = '0;
		if (req_q.pattern_tagged && ({28'd0, req_q.pattern_number} < PATTERNS))
			tag_bit[req_q.pattern_number] = 1'b1;
	end

	logic [VW-1:0] sym_bit;
	always_comb begin
		sym_bit = '0;
		if (sym_ok)
			sym_bit[rsym] = 1'b1;
	end

	// status as known when the request arrives; a letter that finds no free node sets ST_FULL in S_L_DO
	status_t acc_status;
	always_comb begin
		acc_status = ST_OK;
		case (func_t'(in_ch.data.func))
			FN_LETTER, FN_END: if (ovf_q) acc_status = ST_FULL;
			FN_TEXT: if (!built_q) acc_status = ST_NOT_BUILT;
			default: ;
		endcase
	end
	logic [31:0] acc_total;
	assign acc_total = (in_ch.data.func == FN_CLEAR) ? 32'd0 : total_q;

	logic new_node;
	assign new_node = sym_ok && !v_rd[rsym] && (used_q < NODES);

	logic [8:0] cnt_sum;
	assign cnt_sum = {1'b0, cnt_f_q} + {8'd0, endc_q};
	logic [32:0] tot_sum;
	assign tot_sum = {1'b0, total_q} + {25'd0, n_rd};
	logic [31:0] tot_sat;
	assign tot_sat = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];

	// memory control, driven from state
	always_comb begin
		g_we = 1'b0; g_wa = {ins_q, rsym}; g_wd = used_q[NW-1:0]; g_ra = {ins_q, rsym};
		v_we = 1'b0; v_wa = ins_q; v_wd = v_rd | sym_bit; v_ra = ins_q;
		f_we = 1'b0; f_wa = c_q; f_wd = f_q; f_ra = u_q;
		n_we = 1'b0; n_wa = c_q; n_wd = cnt_sum[8] ? 8'hFF : cnt_sum[7:0]; n_ra = f_q;
		m_we = 1'b0; m_wa = c_q; m_wd = m_rd | msk_f_q; m_ra = f_q;
		q_we = 1'b0; q_wa = tail_q[NW-1:0]; q_wd = c_q; q_ra = head_q[NW-1:0];
		case (state_q)
			S_BOOT, S_CLR: begin
				v_we = 1'b1; v_wa = '0; v_wd = '0;
				m_we = 1'b1; m_wa = '0; m_wd = '0;
			end
			S_L_DO: begin
				g_we = new_node; v_we = new_node;
			end
			S_L_NEW: begin
				v_we = 1'b1; v_wa = used_q[NW-1:0]; v_wd = '0;
				m_we = 1'b1; m_wa = used_q[NW-1:0]; m_wd = '0;
			end
			S_E_RD: m_ra = ins_q;
			S_E_DO: begin
				v_we = 1'b1; v_wd = v_rd | END_BIT;
				m_we = 1'b1; m_wa = ins_q; m_wd = m_rd | tag_bit;
			end
			S_B_INIT: begin
				f_we = 1'b1; f_wa = '0; f_wd = '0;
				n_we = 1'b1; n_wa = '0; n_wd = 8'd0;
				q_we = 1'b1; q_wa = '0; q_wd = '0;
			end
			S_B_URD: v_ra = u_q;
			S_B_SYM: g_ra = {u_q, s_q};
			S_B_PRD: begin
				v_ra = p_q; f_ra = p_q; g_ra = {p_q, s_q};
			end
			S_B_CRD: v_ra = c_q;
			S_B_CWT: m_ra = c_q;
			S_B_MWT: begin
				f_we = 1'b1; n_we = 1'b1; m_we = 1'b1;
				q_we = (tail_q < NODES);
			end
			S_T_RD: begin
				v_ra = u_q; g_ra = {u_q, rsym};
			end
			S_T_RES: begin
				n_ra = c_q; m_ra = c_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
			used_q <= CW'(1); ins_q <= '0; mcur_q <= '0;
			u_q <= '0; fu_q <= '0; p_q <= '0; c_q <= '0; f_q <= '0;
			head_q <= '0; tail_q <= '0; s_q <= '0; ucv_q <= '0;
			total_q <= '0; built_q <= 1'b0; ovf_q <= 1'b0;
			req_q <= '0; wk_q <= '0; res_q <= '0; res_v_q <= 1'b0;
			cnt_f_q <= '0; msk_f_q <= '0; endc_q <= 1'b0;
		end else begin
			res_v_q <= out_load || (res_v_q && !out_ch.ready);
			if (out_load) res_q <= wk_q;
			case (state_q)
				S_BOOT: state_q <= S_IDLE;
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					req_q <= in_ch.data;
					wk_q <= '{status: acc_status, matches_here: 8'd0,
						total_matches: acc_total, pattern_mask: '0};
					case (func_t'(in_ch.data.func))
						FN_CLEAR: begin
							used_q <= CW'(1); ins_q <= '0; mcur_q <= '0;
							total_q <= '0; built_q <= 1'b0; ovf_q <= 1'b0;
							state_q <= S_CLR;
						end
						FN_LETTER: begin
							built_q <= 1'b0;
							state_q <= ovf_q ? S_OUT : S_L_RD;
						end
						FN_END: begin
							built_q <= 1'b0;
							if (ovf_q) begin
								ovf_q <= 1'b0; ins_q <= '0; state_q <= S_OUT;
							end else if (ins_q == '0) state_q <= S_OUT;
							else state_q <= S_E_RD;
						end
						FN_BUILD: state_q <= S_B_INIT;
						FN_TEXT: begin
							if (!built_q) state_q <= S_OUT;
							else begin
								u_q <= mcur_q; state_q <= S_T_RD;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_CLR: state_q <= S_OUT;
				S_L_RD: state_q <= S_L_DO;
				S_L_DO: begin
					if (!sym_ok) state_q <= S_OUT;
					else if (v_rd[rsym]) begin
						ins_q <= g_rd; state_q <= S_OUT;
					end else if (used_q < NODES) state_q <= S_L_NEW;
					else begin
						ovf_q <= 1'b1; wk_q.status <= ST_FULL; state_q <= S_OUT;
					end
				end
				S_L_NEW: begin
					ins_q <= used_q[NW-1:0]; used_q <= used_q + CW'(1);
					state_q <= S_OUT;
				end
				S_E_RD: state_q <= S_E_DO;
				S_E_DO: begin
					ins_q <= '0; state_q <= S_OUT;
				end
				S_B_INIT: begin
					head_q <= '0; tail_q <= CW'(1); state_q <= S_B_POP;
				end
				S_B_POP: begin
					if (head_q >= tail_q) begin
						built_q <= 1'b1; mcur_q <= '0; total_q <= '0;
						wk_q.total_matches <= '0; state_q <= S_OUT;
					end else state_q <= S_B_POPW;
				end
				S_B_POPW: begin
					u_q <= q_rd; head_q <= head_q + CW'(1); s_q <= '0;
					state_q <= S_B_URD;
				end
				S_B_URD: state_q <= S_B_UWT;
				S_B_UWT: begin
					ucv_q <= v_rd[ALPHABET-1:0]; fu_q <= f_rd; state_q <= S_B_SYM;
				end
				S_B_SYM: begin
					if (ucv_q[s_q]) state_q <= S_B_GWT;
					else if (s_q == SW'(ALPHABET-1)) state_q <= S_B_POP;
					else s_q <= s_q + SW'(1);
				end
				S_B_GWT: begin
					c_q <= g_rd;
					if (u_q == '0) begin
						f_q <= '0; state_q <= S_B_CRD;
					end else begin
						p_q <= fu_q; state_q <= S_B_PRD;
					end
				end
				S_B_PRD: state_q <= S_B_PWT;
				// failure walk: stop at a node with this child or at root
				S_B_PWT: begin
					if (v_rd[s_q]) begin
						f_q <= g_rd; state_q <= S_B_CRD;
					end else if (p_q == '0) begin
						f_q <= '0; state_q <= S_B_CRD;
					end else begin
						p_q <= f_rd; state_q <= S_B_PRD;
					end
				end
				S_B_CRD: state_q <= S_B_CWT;
				S_B_CWT: begin
					cnt_f_q <= n_rd; msk_f_q <= m_rd; endc_q <= v_rd[ALPHABET];
					state_q <= S_B_MWT;
				end
				S_B_MWT: begin
					if (tail_q < NODES) tail_q <= tail_q + CW'(1);
					if (s_q == SW'(ALPHABET-1)) state_q <= S_B_POP;
					else begin
						s_q <= s_q + SW'(1); state_q <= S_B_SYM;
					end
				end
				S_T_RD: state_q <= S_T_WT;
				S_T_WT: begin
					if (!sym_ok) begin
						c_q <= '0; state_q <= S_T_RES;
					end else if (v_rd[rsym]) begin
						c_q <= g_rd; state_q <= S_T_RES;
					end else if (u_q == '0) begin
						c_q <= '0; state_q <= S_T_RES;
					end else begin
						u_q <= f_rd; state_q <= S_T_RD;
					end
				end
				S_T_RES: state_q <= S_T_DONE;
				S_T_DONE: begin
					mcur_q <= c_q;
					total_q <= tot_sat;
					wk_q <= '{status: ST_OK, matches_here: n_rd, total_matches: tot_sat,
						pattern_mask: m_rd};
					state_q <= S_OUT;
				end
				S_OUT: if (!res_v_q || out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ACM_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ch.ready, state_q == S_IDLE,
		"ready outside idle")
	`ACM_ASSERT_NXT(a_hold_result, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.data), "result changed while stalled")
	`ACM_ASSERT_IMP(a_used_range, clk, arst_n, 1'b1,
		used_q <= NODES && used_q != '0, "node count out of range")
endmodule

[tb/aho_corasick_multi_pattern_matcher_tb.sv]
`timescale 1ns / 1ps
module aho_corasick_multi_pattern_matcher_tb;
	import acm_pkg::*;

	localparam int NODES    = 256;
	localparam int ALPHABET = 26;
	localparam int PATTERNS = 16;
	localparam int STALL_LIMIT = 100000;

	class match_scoreboard;
		bit [7:0]  child[NODES][ALPHABET];
		bit        has_child[NODES][ALPHABET];
		bit [7:0]  fail_to[NODES];
		bit        is_end[NODES];
		bit [7:0]  suffix_count[NODES];
		bit [15:0] suffix_tags[NODES];
		int        node_count;
		bit [7:0]  insert_at;
		bit [7:0]  match_at;
		bit [31:0] total;
		bit        built;
		bit        dropping;
		out_item_t pending[$];
		int        errors;

		function new();
			errors = 0;
			clear_trie();
		endfunction

		function void clear_trie();
			for (int n = 0; n < NODES; n++) begin
				for (int s = 0; s < ALPHABET; s++) begin
					child[n][s] = 0;
					has_child[n][s] = 0;
				end
				fail_to[n] = 0;
				is_end[n] = 0;
				suffix_count[n] = 0;
				suffix_tags[n] = 0;
			end
			node_count = 1;
			insert_at = 0;
			match_at = 0;
			total = 0;
			built = 0;
			dropping = 0;
		endfunction

		function void build_links();
			int bq[NODES];
			int head, tail;
			int u, c, f, p, sum;
			head = 0;
			tail = 0;
			bq[tail] = 0;
			tail++;
			fail_to[0] = 0;
			suffix_count[0] = 0;
			while (head < tail) begin
				u = bq[head];
				head++;
				for (int s = 0; s < ALPHABET; s++) begin
					if (!has_child[u][s])
						continue;
					c = child[u][s];
					f = 0;
					if (tail < NODES) begin
						bq[tail] = c;
						tail++;
					end
					if (u != 0) begin
						p = fail_to[u];
						while (p != 0 && !has_child[p][s])
							p = fail_to[p];
						if (has_child[p][s])
							f = child[p][s];
					end
					fail_to[c] = f;
					sum = suffix_count[f] + is_end[c];
					suffix_count[c] = (sum > 255) ? 8'd255 : sum[7:0];
					suffix_tags[c] |= suffix_tags[f];
				end
			end
			match_at = 0;
			total = 0;
			built = 1;
		endfunction

		// work out the answer to an accepted request
		function void note_request(in_item_t it);
			out_item_t r;
			int u, n;
			bit [32:0] t;
			r = '0;
			r.status = ST_OK;
			case (it.func)
				FN_CLEAR: clear_trie();
				FN_LETTER: begin
					built = 0;
					if (dropping)
						r.status = ST_FULL;
					else if (it.symbol < ALPHABET) begin
						if (has_child[insert_at][it.symbol])
							insert_at = child[insert_at][it.symbol];
						else if (node_count < NODES) begin
							n = node_count++;
							for (int s = 0; s < ALPHABET; s++)
								has_child[n][s] = 0;
							is_end[n] = 0;
							suffix_tags[n] = 0;
							suffix_count[n] = 0;
							fail_to[n] = 0;
							child[insert_at][it.symbol] = n;
							has_child[insert_at][it.symbol] = 1;
							insert_at = n;
						end else begin
							dropping = 1;
							r.status = ST_FULL;
						end
					end
				end
				FN_END: begin
					built = 0;
					if (dropping) begin
						r.status = ST_FULL;
						dropping = 0;
					end else if (insert_at != 0) begin
						is_end[insert_at] = 1;
						if (it.pattern_tagged && it.pattern_number < PATTERNS)
							suffix_tags[insert_at][it.pattern_number] = 1'b1;
					end
					insert_at = 0;
				end
				FN_BUILD: build_links();
				FN_TEXT: begin
					if (!built)
						r.status = ST_NOT_BUILT;
					else begin
						u = match_at;
						if (it.symbol < ALPHABET) begin
							while (u != 0 && !has_child[u][it.symbol])
								u = fail_to[u];
							u = has_child[u][it.symbol] ? child[u][it.symbol] : 0;
						end else
							u = 0;
						match_at = u;
						r.matches_here = suffix_count[u];
						r.pattern_mask = suffix_tags[u];
						t = total + suffix_count[u];
						total = t[32] ? 32'hFFFF_FFFF : t[31:0];
					end
				end
				default: ;
			endcase
			r.total_matches = total;
			pending = {pending, r};
		endfunction

		function void check_result(out_item_t got);
			out_item_t w;
			if (pending.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.status !== w.status) begin
				$error("status exp %0d got %0d", w.status, got.status);
				errors++;
			end
			if (got.matches_here !== w.matches_here) begin
				$error("matches_here exp %0d got %0d", w.matches_here, got.matches_here);
				errors++;
			end
			if (got.total_matches !== w.total_matches) begin
				$error("total_matches exp %0d got %0d", w.total_matches, got.total_matches);
				errors++;
			end
			if (got.pattern_mask !== w.pattern_mask) begin
				$error("pattern_mask exp %h got %h", w.pattern_mask, got.pattern_mask);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	acm_stream_if #(.T(in_item_t))  in_ch ();
	acm_stream_if #(.T(out_item_t)) out_ch ();

	aho_corasick_multi_pattern_matcher #(
		.NODES(NODES), .ALPHABET(ALPHABET), .PATTERNS(PATTERNS)
	) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);

	match_scoreboard sb;
	int src_idle_pct;
	int snk_stall_pct;
	int sent;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_request(in_ch.data);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.data);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t req(func_t f, int sym, int tag = 0, int num = 0);
		in_item_t it;
		it.func = f;
		it.symbol = sym[4:0];
		it.pattern_tagged = tag[0];
		it.pattern_number = num[3:0];
		return it;
	endfunction

	task automatic send(in_item_t it);
		if ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic add_pattern(int len, int letters);
		for (int i = 0; i < len; i++)
			send(req(FN_LETTER, $urandom_range(letters - 1)));
		send(req(FN_END, $urandom_range(31), $urandom_range(1), $urandom_range(15)));
	endtask

	task automatic run_session(bit fill_trie);
		int letters, np, nt;
		letters = fill_trie ? ALPHABET : $urandom_range(4, 2);
		if (fill_trie || $urandom_range(1))
			send(req(FN_CLEAR, $urandom_range(31), $urandom_range(1), $urandom_range(15)));
		np = fill_trie ? 45 : $urandom_range(6, 1);
		for (int i = 0; i < np; i++)
			add_pattern(fill_trie ? $urandom_range(8, 6) : $urandom_range(5, 1), letters);
		// noise: unused codes, stray letters
		if ($urandom_range(9) == 0)
			send(req(func_t'($urandom_range(7, 5)), $urandom_range(31),
				$urandom_range(1), $urandom_range(15)));
		if ($urandom_range(19) == 0)
			send(req(FN_LETTER, $urandom_range(31, 26)));
		if ($urandom_range(99) < 85)
			send(req(FN_BUILD, $urandom_range(31)));
		nt = $urandom_range(40, 15);
		for (int i = 0; i < nt; i++)
			send(req(FN_TEXT, ($urandom_range(19) == 0) ? $urandom_range(31)
				: $urandom_range(letters - 1), $urandom_range(1), $urandom_range(15)));
	endtask

	initial begin
		bit filled;
		sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		sent = 0;
		quiet_cycles = 0;
		filled = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: text before build, empty end, unused codes, tags at extremes
		send(req(FN_TEXT, 0));
		send(req(FN_END, 0, 1, 3));
		send(req(func_t'(5), 31, 1, 15));
		send(req(func_t'(6), 0));
		send(req(func_t'(7), 17, 1, 8));
		send(req(FN_LETTER, 31));
		send(req(FN_LETTER, 0));
		send(req(FN_LETTER, 1));
		send(req(FN_END, 0, 1, 15));
		send(req(FN_LETTER, 1));
		send(req(FN_END, 25, 1, 0));
		send(req(FN_LETTER, 25));
		send(req(FN_END, 0, 0, 7));
		send(req(FN_BUILD, 0));
		send(req(FN_TEXT, 0));
		send(req(FN_TEXT, 1));
		send(req(FN_TEXT, 31));
		send(req(FN_TEXT, 25));
		send(req(FN_TEXT, 1));
		send(req(FN_LETTER, 2));
		send(req(FN_TEXT, 0));
		send(req(FN_CLEAR, 0));
		send(req(FN_TEXT, 1));

		while (sent < 1100) begin
			if (sent < 275) begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end else if (sent < 550) begin
				src_idle_pct = 80;
				snk_stall_pct = 0;
			end else if (sent < 825) begin
				src_idle_pct = 0;
				snk_stall_pct = 80;
			end else begin
				src_idle_pct = 7;
				snk_stall_pct = 7;
			end
			if (!filled && sent > 150) begin
				filled = 1;
				run_session(1'b1);
			end else
				run_session(1'b0);
		end
		in_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
